// ===== hdl/mqps_pkg.sv =====
`timescale 1ns / 1ps

package mqps_pkg;

    localparam int MAX_QUEUES = 4;
    localparam int SIZE_W     = 5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5;
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_POP    = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_POPPED    = 3'd4,
        ST_EVICTED   = 3'd5,
        ST_TICK_DONE = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_CMP_RD,
        S_CMP_EV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [9:0]  prio;
        logic [15:0] age;
    } entry_t;

    typedef struct packed {
        status_t           status;
        logic [1:0]        queue;
        logic [7:0]        id;
        logic [SIZE_W-1:0] size;
    } result_t;

endpackage

// ===== hdl/mqps_ram.sv =====
`timescale 1ns / 1ps

module mqps_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/multi_queue_priority_sorter.sv =====
`timescale 1ns / 1ps

// Bank of NUM_QUEUES sorted priority queues of CAPACITY entries each, held in
// one RAM and worked by a single read-evaluate-write unit. Insert walks from
// the tail towards the head; remove, pop and tick sweep every entry of the
// queue(s) concerned (all entries of all queues for a tick) and compact the
// queue in place. s_ready is low until the item's last result has been
// issued, also while a result waits on m_ready. A tick yields one result per
// eviction, last set on the final one, or a single ST_TICK_DONE result when
// nothing is evicted.
module multi_queue_priority_sorter
    import mqps_pkg::*;
#(
    parameter int NUM_QUEUES = 4,
    parameter int CAPACITY   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [1:0]  s_queue_sel,
    input  logic [7:0]  s_item_id,
    input  logic [9:0]  s_priority_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_out_queue,
    output logic [7:0]  m_out_id,
    output logic [4:0]  m_queue_size,
    output logic        m_last,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int DEPTH = NUM_QUEUES * CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [1:0]        q_reg, q_next;
    logic [7:0]        id_reg, id_next;
    logic [9:0]        prio_reg, prio_next;
    logic [SIZE_W-1:0] r_reg, r_next;
    logic [SIZE_W-1:0] w_reg, w_next;
    logic              found_reg, found_next;
    logic [7:0]        fid_reg, fid_next;
    logic              pend_reg, pend_next;
    result_t           pres_reg, pres_next;
    result_t           fin_reg, fin_next;
    logic [15:0]       timeout_reg;
    logic [SIZE_W-1:0] cnt_reg [MAX_QUEUES];
    logic [SIZE_W-1:0] cnt_next [MAX_QUEUES];

    logic              mv_reg, mv_next;
    result_t           mres_reg, mres_next;
    logic              mlast_reg, mlast_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    entry_t            wr_data, rd_data;
    logic [SIZE_W-1:0] n_cur;
    logic              can_emit;
    logic [15:0]       aged;
    logic              drop;
    entry_t            new_e;

    mqps_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign n_cur    = cnt_reg[q_reg];
    assign can_emit = !mv_reg || m_ready;
    assign aged     = (rd_data.age < AGE_MAX) ? rd_data.age + 16'd1 : rd_data.age;
    assign new_e    = '{id: id_reg, prio: prio_reg, age: 16'd0};

    always_comb begin
        if (state_reg == S_INS_RD || state_reg == S_INS_EV) begin
            rd_addr = AW'(int'(q_reg) * CAPACITY + int'(r_reg) - 1);
        end else begin
            rd_addr = AW'(int'(q_reg) * CAPACITY + int'(r_reg));
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_TICK:   drop = aged > timeout_reg;
            MODE_REMOVE: drop = !found_reg && (rd_data.id == id_reg);
            MODE_POP:    drop = r_reg == '0;
            default:     drop = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mv_reg      <= 1'b0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
            for (int i = 0; i < MAX_QUEUES; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
        mode_reg  <= mode_next;
        q_reg     <= q_next;
        id_reg    <= id_next;
        prio_reg  <= prio_next;
        r_reg     <= r_next;
        w_reg     <= w_next;
        fid_reg   <= fid_next;
        pres_reg  <= pres_next;
        fin_reg   <= fin_next;
        mres_reg  <= mres_next;
        mlast_reg <= mlast_next;
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        q_next     = q_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        found_next = found_reg;
        fid_next   = fid_reg;
        pend_next  = pend_reg;
        pres_next  = pres_reg;
        fin_next   = fin_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        mres_next  = mres_reg;
        mlast_next = mlast_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(int'(q_reg) * CAPACITY + int'(w_reg));
        wr_data    = rd_data;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next  = mode_t'(s_mode);
                    q_next     = s_queue_sel;
                    id_next    = s_item_id;
                    prio_next  = s_priority_req;
                    r_next     = '0;
                    w_next     = '0;
                    found_next = 1'b0;
                    pend_next  = 1'b0;
                    if (mode_t'(s_mode) == MODE_TICK) begin
                        q_next     = '0;
                        state_next = S_CMP_RD;
                    end else if (int'(s_queue_sel) >= NUM_QUEUES) begin
                        fin_next   = '{ST_NOT_FOUND, s_queue_sel, s_item_id, '0};
                        state_next = S_FIN;
                    end else if (mode_t'(s_mode) == MODE_INSERT) begin
                        if (int'(cnt_reg[s_queue_sel]) >= CAPACITY) begin
                            fin_next = '{ST_FULL, s_queue_sel, s_item_id,
                                         cnt_reg[s_queue_sel]};
                            state_next = S_FIN;
                        end else begin
                            r_next     = cnt_reg[s_queue_sel];
                            state_next = S_INS_RD;
                        end
                    end else begin
                        state_next = S_CMP_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (r_reg == '0) begin
                    wr_en           = 1'b1;
                    wr_addr         = AW'(int'(q_reg) * CAPACITY);
                    wr_data         = new_e;
                    cnt_next[q_reg] = n_cur + 1'b1;
                    fin_next        = '{ST_INSERTED, q_reg, id_reg, n_cur + 1'b1};
                    state_next      = S_FIN;
                end else begin
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV: begin
                wr_en   = 1'b1;
                wr_addr = AW'(int'(q_reg) * CAPACITY + int'(r_reg));
                if (rd_data.prio < prio_reg) begin
                    wr_data    = rd_data;
                    r_next     = r_reg - 1'b1;
                    state_next = S_INS_RD;
                end else begin
                    wr_data         = new_e;
                    cnt_next[q_reg] = n_cur + 1'b1;
                    fin_next        = '{ST_INSERTED, q_reg, id_reg, n_cur + 1'b1};
                    state_next      = S_FIN;
                end
            end
            S_CMP_RD: begin
                if (r_reg >= n_cur) begin
                    cnt_next[q_reg] = w_reg;
                    if (mode_reg == MODE_TICK) begin
                        if (q_reg == 2'(NUM_QUEUES - 1)) begin
                            fin_next   = pend_reg ? pres_reg
                                                  : result_t'{ST_TICK_DONE, 2'd0, 8'd0, '0};
                            pend_next  = 1'b0;
                            state_next = S_FIN;
                        end else begin
                            q_next = q_reg + 1'b1;
                            r_next = '0;
                            w_next = '0;
                        end
                    end else if (found_reg) begin
                        fin_next = '{(mode_reg == MODE_REMOVE) ? ST_REMOVED : ST_POPPED,
                                     q_reg, fid_reg, w_reg};
                        state_next = S_FIN;
                    end else begin
                        fin_next = '{ST_NOT_FOUND, q_reg,
                                     (mode_reg == MODE_REMOVE) ? id_reg : 8'd0, w_reg};
                        state_next = S_FIN;
                    end
                end else begin
                    state_next = S_CMP_EV;
                end
            end
            S_CMP_EV: begin
                if (drop) begin
                    if (mode_reg != MODE_TICK) begin
                        found_next = 1'b1;
                        fid_next   = rd_data.id;
                        r_next     = r_reg + 1'b1;
                        state_next = S_CMP_RD;
                    end else if (!pend_reg || can_emit) begin
                        if (pend_reg) begin
                            mv_next    = 1'b1;
                            mres_next  = pres_reg;
                            mlast_next = 1'b0;
                        end
                        pend_next  = 1'b1;
                        pres_next  = '{ST_EVICTED, q_reg, rd_data.id,
                                       n_cur - r_reg + w_reg - 1'b1};
                        r_next     = r_reg + 1'b1;
                        state_next = S_CMP_RD;
                    end
                end else begin
                    wr_en = 1'b1;
                    if (mode_reg == MODE_TICK) begin
                        wr_data.age = aged;
                    end
                    w_next     = w_reg + 1'b1;
                    r_next     = r_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_FIN: begin
                if (can_emit) begin
                    mv_next    = 1'b1;
                    mres_next  = fin_reg;
                    mlast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_ready      = state_reg == S_IDLE;
    assign m_valid      = mv_reg;
    assign m_status     = mres_reg.status;
    assign m_out_queue  = mres_reg.queue;
    assign m_out_id     = mres_reg.id;
    assign m_queue_size = mres_reg.size;
    assign m_last       = mlast_reg;

endmodule

// ===== hdl/mqps_checker.sv =====
`timescale 1ns / 1ps

module mqps_checker
    import mqps_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [1:0] m_out_queue,
    input logic [7:0] m_out_id,
    input logic [4:0] m_queue_size,
    input logic       m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_id)
            && $stable(m_out_queue) && $stable(m_queue_size) && $stable(m_last))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready again straight after a request");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_TICK_DONE)
        else $error("bad status code");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_EVICTED |-> m_last)
        else $error("single result without last");

    a_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_TICK_DONE |->
            m_out_id == 8'd0 && m_queue_size == 5'd0 && m_out_queue == 2'd0)
        else $error("tick done with payload");

endmodule

bind multi_queue_priority_sorter mqps_checker u_mqps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_out_queue  (m_out_queue),
    .m_out_id     (m_out_id),
    .m_queue_size (m_queue_size),
    .m_last       (m_last)
);
